### hw/rtl/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg
// Types, token codes and the per-character scan function of the token scanner.
// ----------------------------------------------------------------------------
package stsc_pkg;

   localparam int PosW = 25;
   typedef logic [PosW-1:0] pos_type;

   typedef enum logic [4:0] {
      M_IDLE, M_COMMENT, M_SKIP, M_STRING,
      M_HEX_X, M_HEX_DIG, M_HEX_FRAC, M_HEX_ESIGN, M_HEX_EFIRST, M_HEX_EDIG,
      M_BIN_B, M_BIN_DIG, M_OCT_O, M_OCT_DIG,
      M_DEC_DIG, M_DEC_ESIGN, M_DEC_EFIRST, M_DEC_EDIG, M_IDENT
   } mode_type;

   localparam logic [4:0] KIND_START  = 5'd0;
   localparam logic [4:0] KIND_LPAREN = 5'd1;
   localparam logic [4:0] KIND_RPAREN = 5'd2;
   localparam logic [4:0] KIND_LBRACK = 5'd3;
   localparam logic [4:0] KIND_RBRACK = 5'd4;
   localparam logic [4:0] KIND_COMMA  = 5'd5;
   localparam logic [4:0] KIND_EQUAL  = 5'd6;
   localparam logic [4:0] KIND_LBRACE = 5'd7;
   localparam logic [4:0] KIND_RBRACE = 5'd8;
   localparam logic [4:0] KIND_ARROW  = 5'd9;
   localparam logic [4:0] KIND_RETURN = 5'd10;
   localparam logic [4:0] KIND_STRING = 5'd11;
   localparam logic [4:0] KIND_FLOAT  = 5'd12;
   localparam logic [4:0] KIND_INT    = 5'd13;
   localparam logic [4:0] KIND_DOT    = 5'd14;
   localparam logic [4:0] KIND_IDENT  = 5'd15;
   localparam logic [4:0] KIND_SIG    = 5'd16;
   localparam logic [4:0] KIND_AS     = 5'd17;
   localparam logic [4:0] KIND_MUT    = 5'd18;
   localparam logic [4:0] KIND_END    = 5'd19;
   localparam logic [4:0] KIND_ERROR  = 5'd20;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_STR_NL     = 4'd1;
   localparam logic [3:0] ERR_STR_END    = 4'd2;
   localparam logic [3:0] ERR_HEX_EXP    = 4'd3;
   localparam logic [3:0] ERR_HEX_EMPTY  = 4'd4;
   localparam logic [3:0] ERR_BIN_EMPTY  = 4'd5;
   localparam logic [3:0] ERR_OCT_EMPTY  = 4'd6;
   localparam logic [3:0] ERR_TWO_POINTS = 4'd7;
   localparam logic [3:0] ERR_DEC_EXP    = 4'd8;
   localparam logic [3:0] ERR_UNEXPECTED = 4'd9;

   localparam logic [23:0] KW_SIG = 24'h736967;
   localparam logic [23:0] KW_AS  = 24'h006173;
   localparam logic [23:0] KW_MUT = 24'h6d7574;

   typedef struct packed {
      logic [4:0]  kind;
      logic [3:0]  code;
      logic [19:0] off;
      logic [20:0] len;
      logic [15:0] line;
   } token_type;

   typedef struct packed {
      token_type [3:0] toks;
      logic [2:0]      cnt;
   } bundle_type;

   typedef struct packed {
      mode_type    mode;
      logic        has;
      logic        flt;
      logic        esc;
      logic [23:0] prefix;
      pos_type     tbegin;
      logic [15:0] line;
      logic        halt;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      token_type      tok0;
      token_type      tok1;
      logic [1:0]     cnt;
   } proc_result_type;

   function automatic scan_state_type scan_reset();
      scan_state_type s;
      s = '0;
      s.mode = M_IDLE;
      s.line = 16'd1;
      return s;
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_xdig(logic [7:0] c);
      return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == 8'h00 || c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09 ||
             c == 8'h0c || c == 8'h0b;
   endfunction

   function automatic logic in_stop(logic [7:0] c);
      return is_space(c) || c == "{" || c == "}" || c == "(" || c == ")" || c == "[" ||
             c == "]" || c == 8'h22 || c == "=" || c == "." || c == ",";
   endfunction

   function automatic logic [15:0] line_inc(logic [15:0] l);
      return (l != 16'hffff) ? l + 16'd1 : l;
   endfunction

   function automatic token_type make_tok(logic [4:0] kind, logic [3:0] code, pos_type off,
                                          pos_type len, logic [15:0] line);
      token_type t;
      t.kind = kind;
      t.code = code;
      t.off  = (off > pos_type'(20'hfffff)) ? 20'hfffff : off[19:0];
      t.len  = (len > pos_type'(21'h1fffff)) ? 21'h1fffff : len[20:0];
      t.line = line;
      return t;
   endfunction

   function automatic proc_result_type push_tok(proc_result_type r, token_type t);
      proc_result_type o;
      o = r;
      if (r.cnt == 2'd0) o.tok0 = t;
      else o.tok1 = t;
      o.cnt = r.cnt + 2'd1;
      return o;
   endfunction

   function automatic proc_result_type scan_fail(proc_result_type r, logic [3:0] code,
                                                 pos_type p);
      proc_result_type o;
      o = push_tok(r, make_tok(KIND_ERROR, code, p, '0, r.st.line));
      o.st.halt = 1'b1;
      o.st.mode = M_IDLE;
      return o;
   endfunction

   function automatic pos_type span(pos_type p, pos_type b);
      return (p >= b) ? p - b : '0;
   endfunction

   // a byte seen between tokens
   function automatic proc_result_type idle_step(proc_result_type r, logic [7:0] c,
                                                 logic [7:0] n, pos_type p, pos_type max_pos);
      proc_result_type o;
      logic [4:0] pk;
      logic       punct;
      o = r;
      pk = KIND_START;
      punct = 1'b1;
      if (c == 8'h0a) o.st.line = line_inc(o.st.line);
      case (c)
         "(": pk = KIND_LPAREN;
         ")": pk = KIND_RPAREN;
         "[": pk = KIND_LBRACK;
         "]": pk = KIND_RBRACK;
         ",": pk = KIND_COMMA;
         "=": pk = KIND_EQUAL;
         "{": pk = KIND_LBRACE;
         "}": pk = KIND_RBRACE;
         default: punct = 1'b0;
      endcase
      if (c == "/" && n == "/") begin
         o.st.mode = M_COMMENT;
      end else if (punct) begin
         o = push_tok(o, make_tok(pk, ERR_NONE, p, pos_type'(1), o.st.line));
      end else if (c == "-" && n == ">") begin
         o = push_tok(o, make_tok(KIND_ARROW, ERR_NONE, p, pos_type'(2), o.st.line));
         o.st.mode = M_SKIP;
      end else if (c == "<" && n == "-") begin
         o = push_tok(o, make_tok(KIND_RETURN, ERR_NONE, p, pos_type'(2), o.st.line));
         o.st.mode = M_SKIP;
      end else if (c == 8'h22) begin
         o.st.tbegin = (p < max_pos) ? p + pos_type'(1) : p;
         o.st.esc = 1'b0;
         o.st.mode = M_STRING;
      end else if (c == "0" && (n == "x" || n == "X")) begin
         o.st.tbegin = p; o.st.has = 1'b0; o.st.flt = 1'b0; o.st.mode = M_HEX_X;
      end else if (c == "0" && (n == "b" || n == "B")) begin
         o.st.tbegin = p; o.st.has = 1'b0; o.st.flt = 1'b0; o.st.mode = M_BIN_B;
      end else if (c == "0" && (n == "o" || n == "O")) begin
         o.st.tbegin = p; o.st.has = 1'b0; o.st.flt = 1'b0; o.st.mode = M_OCT_O;
      end else if (is_dig(c) || (c == "-" && is_dig(n))) begin
         o.st.tbegin = p; o.st.has = 1'b0; o.st.flt = 1'b0; o.st.mode = M_DEC_DIG;
      end else if (c == "." && !is_dig(n)) begin
         o = push_tok(o, make_tok(KIND_DOT, ERR_NONE, p, pos_type'(1), o.st.line));
      end else if (!in_stop(c)) begin
         o.st.tbegin = p;
         o.st.prefix = {16'h0, c};
         o.st.mode = M_IDENT;
      end else if (!is_space(c)) begin
         o = scan_fail(o, ERR_UNEXPECTED, p);
      end
      return o;
   endfunction

   function automatic proc_result_type finish_num(proc_result_type r, pos_type p);
      proc_result_type o;
      o = push_tok(r, make_tok(r.st.flt ? KIND_FLOAT : KIND_INT, ERR_NONE, r.st.tbegin,
                               span(p, r.st.tbegin), r.st.line));
      o.st.mode = M_IDLE;
      return o;
   endfunction

   // one byte c with lookahead n at offset p; at most two tokens
   function automatic proc_result_type scan_proc(scan_state_type s, logic [7:0] c,
                                                 logic [7:0] n, pos_type p, logic at_end,
                                                 pos_type max_pos);
      proc_result_type r;
      logic            redo;
      logic            hex_end;
      logic [4:0]      ik;
      pos_type         len;
      r.st = s;
      r.tok0 = '0;
      r.tok1 = '0;
      r.cnt = 2'd0;
      redo = 1'b0;
      hex_end = 1'b0;
      ik = KIND_IDENT;
      len = span(p, s.tbegin);
      if (!s.halt) begin
         case (s.mode)
            M_COMMENT: begin
               if (at_end || c == 8'h0a) begin
                  r.st.line = line_inc(s.line);
                  r.st.mode = M_IDLE;
               end
            end
            M_SKIP: r.st.mode = M_IDLE;
            M_STRING: begin
               if (s.esc) begin
                  r.st.esc = 1'b0;
                  if (c == 8'h0a) r = scan_fail(r, ERR_STR_NL, p);
                  else if (c == 8'h00) r = scan_fail(r, ERR_STR_END, p);
               end else if (c == 8'h22) begin
                  r = push_tok(r, make_tok(KIND_STRING, ERR_NONE, s.tbegin, len, s.line));
                  r.st.mode = M_IDLE;
               end else if (c == 8'h0a) begin
                  r = scan_fail(r, ERR_STR_NL, p);
               end else if (c == 8'h00) begin
                  r = scan_fail(r, ERR_STR_END, p);
               end else if (c == 8'h5c) begin
                  r.st.esc = 1'b1;
               end
            end
            M_HEX_X: r.st.mode = M_HEX_DIG;
            M_HEX_DIG: begin
               if (is_xdig(c)) r.st.has = 1'b1;
               else if (c == "." && is_xdig(n)) begin
                  r.st.flt = 1'b1;
                  r.st.mode = M_HEX_FRAC;
               end else if (c == "p" || c == "P") begin
                  r.st.flt = 1'b1;
                  r.st.mode = M_HEX_ESIGN;
               end else hex_end = 1'b1;
            end
            M_HEX_FRAC: begin
               if (!is_xdig(c)) begin
                  if (c == "p" || c == "P") begin
                     r.st.flt = 1'b1;
                     r.st.mode = M_HEX_ESIGN;
                  end else hex_end = 1'b1;
               end
            end
            M_HEX_ESIGN, M_HEX_EFIRST: begin
               if (s.mode == M_HEX_ESIGN && (c == "+" || c == "-")) r.st.mode = M_HEX_EFIRST;
               else if (!is_dig(c)) r = scan_fail(r, ERR_HEX_EXP, p);
               else r.st.mode = M_HEX_EDIG;
            end
            M_HEX_EDIG: if (!is_dig(c)) hex_end = 1'b1;
            M_BIN_B: r.st.mode = M_BIN_DIG;
            M_BIN_DIG: begin
               if (c == "0" || c == "1") r.st.has = 1'b1;
               else if (!s.has) r = scan_fail(r, ERR_BIN_EMPTY, p);
               else begin r = finish_num(r, p); redo = 1'b1; end
            end
            M_OCT_O: r.st.mode = M_OCT_DIG;
            M_OCT_DIG: begin
               if (c >= "0" && c <= "7") r.st.has = 1'b1;
               else if (!s.has) r = scan_fail(r, ERR_OCT_EMPTY, p);
               else begin r = finish_num(r, p); redo = 1'b1; end
            end
            M_DEC_DIG: begin
               if (is_dig(c)) begin
                  r.st.mode = M_DEC_DIG;
               end else if (c == "." && is_dig(n)) begin
                  if (s.flt) r = scan_fail(r, ERR_TWO_POINTS, p);
                  else r.st.flt = 1'b1;
               end else if (c == "e" || c == "E") begin
                  r.st.flt = 1'b1;
                  r.st.mode = M_DEC_ESIGN;
               end else begin
                  r = finish_num(r, p);
                  redo = 1'b1;
               end
            end
            M_DEC_ESIGN, M_DEC_EFIRST: begin
               if (s.mode == M_DEC_ESIGN && (c == "+" || c == "-")) r.st.mode = M_DEC_EFIRST;
               else if (!is_dig(c)) r = scan_fail(r, ERR_DEC_EXP, p);
               else r.st.mode = M_DEC_EDIG;
            end
            M_DEC_EDIG: begin
               if (!is_dig(c)) begin
                  r = finish_num(r, p);
                  redo = 1'b1;
               end
            end
            M_IDENT: begin
               if (!in_stop(c) && !(c == "-" && n == ">") && !(c == "<" && n == "-") &&
                   !(c == "/" && n == "/")) begin
                  r.st.prefix = {s.prefix[15:0], c};
               end else begin
                  if (len == pos_type'(3) && s.prefix == KW_SIG) ik = KIND_SIG;
                  else if (len == pos_type'(2) && s.prefix == KW_AS) ik = KIND_AS;
                  else if (len == pos_type'(3) && s.prefix == KW_MUT) ik = KIND_MUT;
                  r = push_tok(r, make_tok(ik, ERR_NONE, s.tbegin, len, s.line));
                  r.st.mode = M_IDLE;
                  redo = 1'b1;
               end
            end
            default: begin
               r.st.mode = M_IDLE;
               redo = 1'b1;
            end
         endcase
         if (hex_end) begin
            if (!r.st.has && !r.st.flt) r = scan_fail(r, ERR_HEX_EMPTY, p);
            else begin r = finish_num(r, p); redo = 1'b1; end
         end
         if (redo && !r.st.halt) r = idle_step(r, c, n, p, max_pos);
      end
      return r;
   endfunction

   function automatic bundle_type add_tok(bundle_type b, token_type t);
      bundle_type o;
      o = b;
      if (b.cnt < 3'd4) begin
         o.toks[b.cnt[1:0]] = t;
         o.cnt = b.cnt + 3'd1;
      end
      return o;
   endfunction

   function automatic bundle_type add_proc(bundle_type b, proc_result_type r);
      bundle_type o;
      o = b;
      if (r.cnt != 2'd0) o = add_tok(o, r.tok0);
      if (r.cnt == 2'd2) o = add_tok(o, r.tok1);
      return o;
   endfunction

endpackage

### hw/rtl/stsc_front.sv
// ----------------------------------------------------------------------------
// stsc_front
// Takes one character per cycle while take is high, keeps the lookahead and scan state, and
// forms the bundle of tokens that the character releases.
// ----------------------------------------------------------------------------
module stsc_front #(
   parameter int MAX_FILE_BYTES = 1048576
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          in_char,
   input  logic                end_of_file,
   output stsc_pkg::bundle_type bundle,
   output logic                push
);

   localparam stsc_pkg::pos_type MaxPos = stsc_pkg::pos_type'(MAX_FILE_BYTES);

   stsc_pkg::scan_state_type st_ff, st_in;
   logic [7:0]       la_char_ff, la_char_in;
   logic             la_valid_ff, la_valid_in;
   stsc_pkg::pos_type la_pos_ff, la_pos_in;
   stsc_pkg::pos_type bpos_ff, bpos_in;
   logic             start_sent_ff, start_sent_in;

   always_comb begin
      stsc_pkg::proc_result_type r;
      stsc_pkg::bundle_type      b;
      stsc_pkg::scan_state_type  s;
      stsc_pkg::pos_type         bp_next;
      b = '0;
      s = st_ff;
      r = '0;
      bp_next = (bpos_ff < MaxPos) ? bpos_ff + stsc_pkg::pos_type'(1) : bpos_ff;
      st_in = st_ff;
      la_char_in = la_char_ff;
      la_valid_in = la_valid_ff;
      la_pos_in = la_pos_ff;
      bpos_in = bpos_ff;
      start_sent_in = start_sent_ff;
      if (st_ff.halt) begin
         if (end_of_file) begin
            st_in = stsc_pkg::scan_reset();
            la_char_in = '0;
            la_valid_in = 1'b0;
            la_pos_in = '0;
            bpos_in = '0;
            start_sent_in = 1'b0;
         end
      end else begin
         if (!start_sent_ff) begin
            b = stsc_pkg::add_tok(b, stsc_pkg::make_tok(stsc_pkg::KIND_START,
               stsc_pkg::ERR_NONE, '0, '0, s.line));
         end
         if (la_valid_ff) begin
            r = stsc_pkg::scan_proc(s, la_char_ff, in_char, la_pos_ff, 1'b0, MaxPos);
            b = stsc_pkg::add_proc(b, r);
            s = r.st;
         end
         if (end_of_file) begin
            r = stsc_pkg::scan_proc(s, in_char, 8'h00, bpos_ff, 1'b0, MaxPos);
            b = stsc_pkg::add_proc(b, r);
            s = r.st;
            r = stsc_pkg::scan_proc(s, 8'h00, 8'h00, bp_next, 1'b1, MaxPos);
            b = stsc_pkg::add_proc(b, r);
            s = r.st;
            if (!s.halt) begin
               b = stsc_pkg::add_tok(b, stsc_pkg::make_tok(stsc_pkg::KIND_END,
                  stsc_pkg::ERR_NONE, bp_next, '0, s.line));
            end
            st_in = stsc_pkg::scan_reset();
            la_char_in = '0;
            la_valid_in = 1'b0;
            la_pos_in = '0;
            bpos_in = '0;
            start_sent_in = 1'b0;
         end else begin
            st_in = s;
            la_char_in = in_char;
            la_valid_in = 1'b1;
            la_pos_in = bpos_ff;
            bpos_in = bp_next;
            start_sent_in = 1'b1;
         end
      end
      bundle = b;
      push = take && (b.cnt != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= stsc_pkg::scan_reset();
         la_valid_ff <= 1'b0;
         la_char_ff <= '0;
         la_pos_ff <= '0;
         bpos_ff <= '0;
         start_sent_ff <= 1'b0;
      end else if (take) begin
         st_ff <= st_in;
         la_valid_ff <= la_valid_in;
         la_char_ff <= la_char_in;
         la_pos_ff <= la_pos_in;
         bpos_ff <= bpos_in;
         start_sent_ff <= start_sent_in;
      end
   end

endmodule

### hw/rtl/stsc_queue.sv
// ----------------------------------------------------------------------------
// stsc_queue
// Four-deep queue of token bundles between scanner and output.
// ----------------------------------------------------------------------------
module stsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stsc_pkg::bundle_type push_data,
   input  logic                 pop,
   output stsc_pkg::bundle_type head,
   output logic                 empty,
   output logic                 full
);

   stsc_pkg::bundle_type mem_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
      empty = (cnt_ff == 3'd0);
      full = (cnt_ff == 3'd4);
      head = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hw/rtl/stsc_back.sv
// ----------------------------------------------------------------------------
// stsc_back
// Walks the head bundle one token per transaction and retires it.
// ----------------------------------------------------------------------------
module stsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  stsc_pkg::bundle_type head,
   input  logic                 empty,
   input  logic                 rsp_stall,
   output logic                 pop,
   output logic                 rsp_valid,
   output stsc_pkg::token_type  tok,
   output logic                 last
);

   logic [1:0] idx_ff, idx_in;

   always_comb begin
      rsp_valid = !empty;
      tok = head.toks[idx_ff];
      last = ({1'b0, idx_ff} == head.cnt - 3'd1);
      pop = rsp_valid && !rsp_stall && last;
      idx_in = idx_ff;
      if (rsp_valid && !rsp_stall) idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

endmodule

### hw/rtl/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner
// Character-serial tokenizer with one byte of lookahead.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | in_char, end_of_file
//  rsp     | out       | rsp_valid/rsp_stall | kind, code, offset, length, line, last
//
//  One character is taken each cycle while the bundle queue has room.
//  A character releases 0..4 tokens as one bundle; the output side sends
//  one token per cycle while rsp_stall is low, and pops a bundle with its last token.
//  req_stall rises only when the four-entry bundle queue is full.
//  Reset is synchronous; the first character after reset or after a file
//  end starts a new file with a START token.
// ----------------------------------------------------------------------------
module source_token_scanner #(
   parameter int MAX_FILE_BYTES = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_char,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [3:0]  rsp_error_code,
   output logic [19:0] rsp_start_offset,
   output logic [20:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_of_run
);

   stsc_pkg::bundle_type bundle, head;
   stsc_pkg::token_type  tok;
   logic push, pop, empty, full, take;

   // a transaction is taken whenever the queue can absorb a worst-case bundle
   assign req_stall = full;
   assign take = req_valid && !full;

   stsc_front #(.MAX_FILE_BYTES(MAX_FILE_BYTES)) u_front (
      .clock(clock), .reset(reset), .take(take), .in_char(req_in_char),
      .end_of_file(req_end_of_file), .bundle(bundle), .push(push)
   );

   stsc_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(bundle), .pop(pop),
      .head(head), .empty(empty), .full(full)
   );

   stsc_back u_back (
      .clock(clock), .reset(reset), .head(head), .empty(empty), .rsp_stall(rsp_stall),
      .pop(pop), .rsp_valid(rsp_valid), .tok(tok), .last(rsp_last_of_run)
   );

   assign rsp_token_kind   = tok.kind;
   assign rsp_error_code   = tok.code;
   assign rsp_start_offset = tok.off;
   assign rsp_token_length = tok.len;
   assign rsp_line_number  = tok.line;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams short source files through the token scanner and checks each token.
// The expected tokens come from a scanner model kept inside this bench.
// Random gaps on the request side and random stalls on the token side are
// applied, with bursts that have no idling at all.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FileMax = 1048576;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [4:0]  kind;
      logic [3:0]  code;
      logic [19:0] offset;
      logic [20:0] length;
      logic [15:0] line;
      logic        last;
   } exp_token_type;

   typedef struct {
      logic [7:0] ch;
      logic       eof;
   } char_type;

   logic        clock, reset;
   logic        req_valid, req_stall, req_end_of_file;
   logic [7:0]  req_in_char;
   logic        rsp_valid, rsp_stall, rsp_last_of_run;
   logic [4:0]  rsp_token_kind;
   logic [3:0]  rsp_error_code;
   logic [19:0] rsp_start_offset;
   logic [20:0] rsp_token_length;
   logic [15:0] rsp_line_number;

   source_token_scanner dut (.*);

   // transactions waiting to be driven, and tokens still owed by the block
   char_type      chars_pending[$];
   exp_token_type tokens_due[$];
   logic [7:0]    text_buf[$];

   int errors = 0;
   int cycles = 0;
   int files_sent = 0;
   int chars_sent = 0;
   int tokens_seen = 0;
   bit req_took = 0;
   bit rsp_took = 0;

   // ---------------------------------------------------------------------
   // Scanner model state
   // ---------------------------------------------------------------------
   stsc_pkg::mode_type sc_mode;
   logic [7:0]  la_char;
   bit          la_valid;
   int unsigned la_pos, cur_pos, tok_begin, line_cnt;
   bit          has_digits, is_float, esc_pending, started, halted;
   logic [23:0] name_tail;
   int          step_count;

   function automatic void scanner_clear();
      sc_mode = stsc_pkg::M_IDLE;
      la_char = 8'h00;
      la_valid = 0;
      la_pos = 0;
      cur_pos = 0;
      tok_begin = 0;
      line_cnt = 1;
      has_digits = 0;
      is_float = 0;
      esc_pending = 0;
      name_tail = '0;
      started = 0;
      halted = 0;
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit hex_digit(logic [7:0] c);
      return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic bit blank(logic [7:0] c);
      return c == 8'h00 || c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09 ||
             c == 8'h0c || c == 8'h0b;
   endfunction

   // characters that end an identifier
   function automatic bit delimiter(logic [7:0] c);
      return blank(c) || c == "{" || c == "}" || c == "(" || c == ")" || c == "[" ||
             c == "]" || c == 8'h22 || c == "=" || c == "." || c == ",";
   endfunction

   function automatic void bump_line();
      if (line_cnt < 65535) line_cnt++;
   endfunction

   function automatic void emit_token(logic [4:0] kind, logic [3:0] code,
                                      int unsigned off, int unsigned len);
      exp_token_type t;
      if (step_count >= 4) return;
      t.kind = kind;
      t.code = code;
      t.offset = (off > 32'hfffff) ? 20'hfffff : off[19:0];
      t.length = (len > 32'h1fffff) ? 21'h1fffff : len[20:0];
      t.line = line_cnt[15:0];
      t.last = 0;
      tokens_due.push_back(t);
      step_count++;
   endfunction

   function automatic void raise_error(logic [3:0] code, int unsigned p);
      emit_token(stsc_pkg::KIND_ERROR, code, p, 0);
      halted = 1;
      sc_mode = stsc_pkg::M_IDLE;
   endfunction

   function automatic int unsigned text_len(int unsigned p);
      return (p >= tok_begin) ? p - tok_begin : 0;
   endfunction

   function automatic bit close_number(int unsigned p);
      emit_token(is_float ? stsc_pkg::KIND_FLOAT : stsc_pkg::KIND_INT, stsc_pkg::ERR_NONE,
                 tok_begin, text_len(p));
      sc_mode = stsc_pkg::M_IDLE;
      return 1;
   endfunction

   function automatic bit close_hex(int unsigned p);
      if (!has_digits && !is_float) begin
         raise_error(stsc_pkg::ERR_HEX_EMPTY, p);
         return 0;
      end
      return close_number(p);
   endfunction

   function automatic bit after_mantissa(logic [7:0] c, int unsigned p);
      if (c == "p" || c == "P") begin
         is_float = 1;
         sc_mode = stsc_pkg::M_HEX_ESIGN;
         return 0;
      end
      return close_hex(p);
   endfunction

   function automatic void start_number(int unsigned p, stsc_pkg::mode_type m);
      tok_begin = p;
      has_digits = 0;
      is_float = 0;
      sc_mode = m;
   endfunction

   // a character seen between tokens
   function automatic void between_tokens(logic [7:0] c, logic [7:0] n, int unsigned p);
      if (c == 8'h0a) bump_line();
      if (c == "/" && n == "/") begin
         sc_mode = stsc_pkg::M_COMMENT;
         return;
      end
      case (c)
         "(": begin emit_token(stsc_pkg::KIND_LPAREN, stsc_pkg::ERR_NONE, p, 1); return; end
         ")": begin emit_token(stsc_pkg::KIND_RPAREN, stsc_pkg::ERR_NONE, p, 1); return; end
         "[": begin emit_token(stsc_pkg::KIND_LBRACK, stsc_pkg::ERR_NONE, p, 1); return; end
         "]": begin emit_token(stsc_pkg::KIND_RBRACK, stsc_pkg::ERR_NONE, p, 1); return; end
         ",": begin emit_token(stsc_pkg::KIND_COMMA, stsc_pkg::ERR_NONE, p, 1); return; end
         "=": begin emit_token(stsc_pkg::KIND_EQUAL, stsc_pkg::ERR_NONE, p, 1); return; end
         "{": begin emit_token(stsc_pkg::KIND_LBRACE, stsc_pkg::ERR_NONE, p, 1); return; end
         "}": begin emit_token(stsc_pkg::KIND_RBRACE, stsc_pkg::ERR_NONE, p, 1); return; end
         default: ;
      endcase
      if (c == "-" && n == ">") begin
         emit_token(stsc_pkg::KIND_ARROW, stsc_pkg::ERR_NONE, p, 2);
         sc_mode = stsc_pkg::M_SKIP;
      end else if (c == "<" && n == "-") begin
         emit_token(stsc_pkg::KIND_RETURN, stsc_pkg::ERR_NONE, p, 2);
         sc_mode = stsc_pkg::M_SKIP;
      end else if (c == 8'h22) begin
         tok_begin = (p < FileMax) ? p + 1 : p;
         esc_pending = 0;
         sc_mode = stsc_pkg::M_STRING;
      end else if (c == "0" && (n == "x" || n == "X")) begin
         start_number(p, stsc_pkg::M_HEX_X);
      end else if (c == "0" && (n == "b" || n == "B")) begin
         start_number(p, stsc_pkg::M_BIN_B);
      end else if (c == "0" && (n == "o" || n == "O")) begin
         start_number(p, stsc_pkg::M_OCT_O);
      end else if (digit(c) || (c == "-" && digit(n))) begin
         start_number(p, stsc_pkg::M_DEC_DIG);
      end else if (c == "." && !digit(n)) begin
         emit_token(stsc_pkg::KIND_DOT, stsc_pkg::ERR_NONE, p, 1);
      end else if (!delimiter(c)) begin
         tok_begin = p;
         name_tail = {16'h0, c};
         sc_mode = stsc_pkg::M_IDENT;
      end else if (!blank(c)) begin
         raise_error(stsc_pkg::ERR_UNEXPECTED, p);
      end
   endfunction

   // advances the open token; 1 means c must be looked at again as a token start
   function automatic bit inside_token(logic [7:0] c, logic [7:0] n, int unsigned p,
                                       bit at_end);
      int unsigned len;
      forever begin
         case (sc_mode)
            stsc_pkg::M_COMMENT: begin
               if (at_end || c == 8'h0a) begin
                  bump_line();
                  sc_mode = stsc_pkg::M_IDLE;
               end
               return 0;
            end
            stsc_pkg::M_SKIP: begin sc_mode = stsc_pkg::M_IDLE; return 0; end
            stsc_pkg::M_STRING: begin
               if (esc_pending) begin
                  esc_pending = 0;
                  if (c == 8'h0a) raise_error(stsc_pkg::ERR_STR_NL, p);
                  else if (c == 8'h00) raise_error(stsc_pkg::ERR_STR_END, p);
                  return 0;
               end
               if (c == 8'h22) begin
                  emit_token(stsc_pkg::KIND_STRING, stsc_pkg::ERR_NONE, tok_begin,
                             text_len(p));
                  sc_mode = stsc_pkg::M_IDLE;
               end else if (c == 8'h0a) raise_error(stsc_pkg::ERR_STR_NL, p);
               else if (c == 8'h00) raise_error(stsc_pkg::ERR_STR_END, p);
               else if (c == 8'h5c) esc_pending = 1;
               return 0;
            end
            stsc_pkg::M_HEX_X: begin sc_mode = stsc_pkg::M_HEX_DIG; return 0; end
            stsc_pkg::M_HEX_DIG: begin
               if (hex_digit(c)) begin has_digits = 1; return 0; end
               if (c == "." && hex_digit(n)) begin
                  is_float = 1;
                  sc_mode = stsc_pkg::M_HEX_FRAC;
                  return 0;
               end
               return after_mantissa(c, p);
            end
            stsc_pkg::M_HEX_FRAC: begin
               if (hex_digit(c)) return 0;
               return after_mantissa(c, p);
            end
            stsc_pkg::M_HEX_ESIGN: begin
               sc_mode = stsc_pkg::M_HEX_EFIRST;
               if (c == "+" || c == "-") return 0;
            end
            stsc_pkg::M_HEX_EFIRST: begin
               if (!digit(c)) raise_error(stsc_pkg::ERR_HEX_EXP, p);
               else sc_mode = stsc_pkg::M_HEX_EDIG;
               return 0;
            end
            stsc_pkg::M_HEX_EDIG: begin
               if (digit(c)) return 0;
               return close_hex(p);
            end
            stsc_pkg::M_BIN_B: begin sc_mode = stsc_pkg::M_BIN_DIG; return 0; end
            stsc_pkg::M_BIN_DIG: begin
               if (c == "0" || c == "1") begin has_digits = 1; return 0; end
               if (!has_digits) begin raise_error(stsc_pkg::ERR_BIN_EMPTY, p); return 0; end
               return close_number(p);
            end
            stsc_pkg::M_OCT_O: begin sc_mode = stsc_pkg::M_OCT_DIG; return 0; end
            stsc_pkg::M_OCT_DIG: begin
               if (c >= "0" && c <= "7") begin has_digits = 1; return 0; end
               if (!has_digits) begin raise_error(stsc_pkg::ERR_OCT_EMPTY, p); return 0; end
               return close_number(p);
            end
            stsc_pkg::M_DEC_DIG: begin
               if (digit(c)) return 0;
               if (c == "." && digit(n)) begin
                  if (is_float) raise_error(stsc_pkg::ERR_TWO_POINTS, p);
                  else is_float = 1;
                  return 0;
               end
               if (c == "e" || c == "E") begin
                  is_float = 1;
                  sc_mode = stsc_pkg::M_DEC_ESIGN;
                  return 0;
               end
               return close_number(p);
            end
            stsc_pkg::M_DEC_ESIGN: begin
               sc_mode = stsc_pkg::M_DEC_EFIRST;
               if (c == "+" || c == "-") return 0;
            end
            stsc_pkg::M_DEC_EFIRST: begin
               if (!digit(c)) raise_error(stsc_pkg::ERR_DEC_EXP, p);
               else sc_mode = stsc_pkg::M_DEC_EDIG;
               return 0;
            end
            stsc_pkg::M_DEC_EDIG: begin
               if (digit(c)) return 0;
               return close_number(p);
            end
            stsc_pkg::M_IDENT: begin
               if (!delimiter(c) && !(c == "-" && n == ">") && !(c == "<" && n == "-") &&
                   !(c == "/" && n == "/")) begin
                  name_tail = {name_tail[15:0], c};
                  return 0;
               end
               len = text_len(p);
               // keyword check looks only at the last three characters plus the length
               if (len == 3 && name_tail == stsc_pkg::KW_SIG)
                  emit_token(stsc_pkg::KIND_SIG, stsc_pkg::ERR_NONE, tok_begin, len);
               else if (len == 2 && name_tail == stsc_pkg::KW_AS)
                  emit_token(stsc_pkg::KIND_AS, stsc_pkg::ERR_NONE, tok_begin, len);
               else if (len == 3 && name_tail == stsc_pkg::KW_MUT)
                  emit_token(stsc_pkg::KIND_MUT, stsc_pkg::ERR_NONE, tok_begin, len);
               else
                  emit_token(stsc_pkg::KIND_IDENT, stsc_pkg::ERR_NONE, tok_begin, len);
               sc_mode = stsc_pkg::M_IDLE;
               return 1;
            end
            default: begin sc_mode = stsc_pkg::M_IDLE; return 1; end
         endcase
      end
   endfunction

   function automatic void scan_one(logic [7:0] c, logic [7:0] n, int unsigned p,
                                    bit at_end);
      if (halted) return;
      if (inside_token(c, n, p, at_end) && !halted) between_tokens(c, n, p);
   endfunction

   // expected tokens caused by one accepted character
   function automatic void predict_tokens(logic [7:0] c, bit eof);
      int unsigned p;
      step_count = 0;
      if (halted) begin
         // after a syntax error the rest of the file is dropped silently
         if (eof) scanner_clear();
         return;
      end
      if (!started) begin
         emit_token(stsc_pkg::KIND_START, stsc_pkg::ERR_NONE, 0, 0);
         started = 1;
      end
      if (la_valid) scan_one(la_char, c, la_pos, 0);
      p = cur_pos;
      if (cur_pos < FileMax) cur_pos++;
      if (eof) begin
         scan_one(c, 8'h00, p, 0);
         scan_one(8'h00, 8'h00, cur_pos, 1);   // virtual terminator
         if (!halted) emit_token(stsc_pkg::KIND_END, stsc_pkg::ERR_NONE, cur_pos, 0);
         scanner_clear();
      end else begin
         la_char = c;
         la_pos = p;
         la_valid = 1;
      end
      if (step_count > 0) tokens_due[tokens_due.size() - 1].last = 1;
   endfunction

   // ---------------------------------------------------------------------
   // Source text generation
   // ---------------------------------------------------------------------
   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic void put_digits(int count, int radix);
      string hexset;
      hexset = "0123456789abcdefABCDEF";
      for (int i = 0; i < count; i++) begin
         if (radix == 16) text_buf.push_back(hexset[$urandom_range(21, 0)]);
         else text_buf.push_back(8'("0") + 8'($urandom_range(radix - 1, 0)));
      end
   endfunction

   // closes the buffered text as one file; each character is predicted as queued
   function automatic void send_file();
      char_type it;
      foreach (text_buf[i]) begin
         it.ch = text_buf[i];
         it.eof = (i == text_buf.size() - 1);
         chars_pending.push_back(it);
         predict_tokens(it.ch, it.eof);
      end
      chars_sent += text_buf.size();
      files_sent++;
      text_buf.delete();
   endfunction

   function automatic void put_fragment();
      int pick;
      string punct;
      punct = "()[],={}.";
      pick = $urandom_range(15, 0);
      case (pick)
         0: put_text("sig");
         1: put_text("as");
         2: put_text("mut");
         3: begin
            // identifier, sometimes with bytes above 127
            for (int i = $urandom_range(5, 1); i > 0; i--)
               text_buf.push_back($urandom_range(3, 0) == 0 ?
                                  8'($urandom_range(255, 128)) :
                                  8'("a") + 8'($urandom_range(25, 0)));
         end
         4: begin
            if ($urandom_range(1, 0)) put_text("-");
            put_digits($urandom_range(4, 1), 10);
            if ($urandom_range(1, 0)) begin put_text("."); put_digits($urandom_range(3, 1), 10); end
            if ($urandom_range(1, 0)) begin
               put_text($urandom_range(1, 0) ? "e" : "E");
               if ($urandom_range(1, 0)) put_text($urandom_range(1, 0) ? "+" : "-");
               put_digits($urandom_range(2, 1), 10);
            end
         end
         5: begin
            put_text($urandom_range(1, 0) ? "0x" : "0X");
            put_digits($urandom_range(4, 1), 16);
            if ($urandom_range(1, 0)) begin put_text("."); put_digits($urandom_range(2, 1), 16); end
            if ($urandom_range(1, 0)) begin
               put_text($urandom_range(1, 0) ? "p" : "P");
               if ($urandom_range(1, 0)) put_text("-");
               put_digits($urandom_range(2, 1), 10);
            end
         end
         6: begin put_text($urandom_range(1, 0) ? "0b" : "0B"); put_digits($urandom_range(6, 1), 2); end
         7: begin put_text($urandom_range(1, 0) ? "0o" : "0O"); put_digits($urandom_range(4, 1), 8); end
         8: begin
            put_text("\"");
            for (int i = $urandom_range(4, 0); i > 0; i--)
               if ($urandom_range(3, 0) == 0) put_text("\\\"");
               else text_buf.push_back(8'($urandom_range(126, 32)) == 8'h22 ?
                                       8'h41 : 8'($urandom_range(126, 32)));
            put_text("\"");
         end
         9: begin
            put_text("//");
            for (int i = $urandom_range(4, 0); i > 0; i--)
               text_buf.push_back(8'($urandom_range(255, 0)));
            put_text("\n");
         end
         10: put_text($urandom_range(1, 0) ? "->" : "<-");
         11: text_buf.push_back(punct[$urandom_range(8, 0)]);
         12: put_text($urandom_range(1, 0) ? "\n" : "\t");
         13: text_buf.push_back(8'($urandom_range(255, 0)));   // noise
         default: put_text(" ");
      endcase
      if ($urandom_range(2, 0) == 0) put_text(" ");
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_in_char = 8'h00;
      req_end_of_file = 0;
      rsp_stall = 0;
      scanner_clear();

      // directed files: every token kind, each error kind, edge cases
      put_text("sig as mut x(-1.5e+3)[0x1f.8p-2,0b101]{0o17}=\"a\\\"b\".// c\n-> <- . 7");
      send_file();
      put_text("\"ab\ncd\"");                     send_file();   // newline in a string
      put_text("\"ab\\");                         send_file();   // file ends inside a string
      put_text("0x1p z");                         send_file();   // hex exponent without digit
      put_text("0x ");                            send_file();
      put_text("0b2");                            send_file();
      put_text("0o8");                            send_file();
      put_text("1.2.3");                          send_file();   // second decimal point
      put_text("1e;");                            send_file();
      put_text(".5 a b c");                       send_file();   // unexpected char, rest dropped
      put_text("//end");                          send_file();   // end of file inside a comment
      text_buf.push_back(8'h00); text_buf.push_back(8'hff); send_file();

      // random files, mostly well formed
      while (chars_sent < 260) begin
         for (int i = $urandom_range(10, 2); i > 0; i--) put_fragment();
         send_file();
      end

      while (chars_pending.size() != 0 || req_valid) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("%0d files, %0d characters and %0d tokens checked under random gaps and stalls",
               files_sent, chars_sent, tokens_seen);
      if (errors == 0) $display("source_token_scanner: match");
      else $display("source_token_scanner: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == 11) reset <= 0;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout with %0d tokens outstanding", $realtime, tokens_due.size());
         $display("source_token_scanner: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: request side, changes on the falling edge
   // ---------------------------------------------------------------------
   int  req_gap = 0;
   int  rsp_wait = 0;
   bit  req_burst = 0;
   bit  rsp_burst = 0;

   always @(posedge clock) begin
      req_took = req_valid && !req_stall && !reset;
      rsp_took = rsp_valid && !rsp_stall && !reset;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_took) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 0;
            end else if (chars_pending.size() != 0) begin
               req_in_char <= chars_pending[0].ch;
               req_end_of_file <= chars_pending[0].eof;
               void'(chars_pending.pop_front());
               req_valid <= 1;
               // gap before the next transaction; bursts have none
               if ($urandom_range(40, 0) == 0) req_burst = !req_burst;
               req_gap = req_burst ? 0 : $urandom_range(18, 0);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // token side stall, one draw per accepted token
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            if ($urandom_range(40, 0) == 0) rsp_burst = !rsp_burst;
            rsp_wait = rsp_burst ? 0 : $urandom_range(18, 0);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compares every accepted token with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      exp_token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected token kind %0d", $realtime, rsp_token_kind);
         end else begin
            want = tokens_due.pop_front();
            if (rsp_token_kind !== want.kind) begin
               errors++;
               $display("%0t: kind expected %0d actual %0d", $realtime, want.kind,
                        rsp_token_kind);
            end
            if (rsp_error_code !== want.code) begin
               errors++;
               $display("%0t: code expected %0d actual %0d", $realtime, want.code,
                        rsp_error_code);
            end
            if (rsp_start_offset !== want.offset) begin
               errors++;
               $display("%0t: offset expected %0d actual %0d", $realtime, want.offset,
                        rsp_start_offset);
            end
            if (rsp_token_length !== want.length) begin
               errors++;
               $display("%0t: length expected %0d actual %0d", $realtime, want.length,
                        rsp_token_length);
            end
            if (rsp_line_number !== want.line) begin
               errors++;
               $display("%0t: line expected %0d actual %0d", $realtime, want.line,
                        rsp_line_number);
            end
            if (rsp_last_of_run !== want.last) begin
               errors++;
               $display("%0t: last expected %0d actual %0d", $realtime, want.last,
                        rsp_last_of_run);
            end
         end
      end
   end

endmodule

### files.f
hw/rtl/stsc_pkg.sv
hw/rtl/stsc_front.sv
hw/rtl/stsc_queue.sv
hw/rtl/stsc_back.sv
hw/rtl/source_token_scanner.sv
verif/testbench.sv
